@@ src/tpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the triangle primitive assembly block.
// ----------------------------------------------------------------------------
package tpa_pkg;

    // Kept width of a vertex id and width of the in-primitive phase counter
    localparam int VERTEX_ID_BITS = 32;
    localparam int POSITION_BITS  = 16;

    // Port widths fixed by the item format
    localparam int PORT_ID_BITS  = 32;
    localparam int TRI_NUM_BITS  = 32;

    // GL primitive type encoding; codes 10..15 are unknown and give nothing
    typedef enum logic [3:0] {
        PRIM_POINTS     = 4'd0,
        PRIM_LINES      = 4'd1,
        PRIM_LINE_LOOP  = 4'd2,
        PRIM_LINE_STRIP = 4'd3,
        PRIM_TRIANGLES  = 4'd4,
        PRIM_TRI_STRIP  = 4'd5,
        PRIM_TRI_FAN    = 4'd6,
        PRIM_QUADS      = 4'd7,
        PRIM_QUAD_STRIP = 4'd8,
        PRIM_POLYGON    = 4'd9
    } t_prim_type;

    // One incoming vertex item
    typedef struct packed {
        t_prim_type                prim_type;
        logic                      first_vertex;
        logic                      restart_count;
        logic [PORT_ID_BITS-1:0]   vertex_id;
    } t_vertex;

    // One assembled triangle item
    typedef struct packed {
        logic [PORT_ID_BITS-1:0]   corner_a;
        logic [PORT_ID_BITS-1:0]   corner_b;
        logic [PORT_ID_BITS-1:0]   corner_c;
        logic [TRI_NUM_BITS-1:0]   triangle_number;
    } t_triangle;

endpackage

@@ src/tpa_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_in_stage
// Input register with a one-entry skid buffer, so the upstream stall is a
// registered signal and items keep flowing one per cycle while i_advance is high.
// ----------------------------------------------------------------------------
module tpa_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tpa_pkg::t_vertex i_item,
    input  logic             i_advance,
    output logic             o_valid,
    output tpa_pkg::t_vertex o_item
);
    import tpa_pkg::*;

    logic    r_valid;
    logic    r_skid_valid;
    t_vertex r_item;
    t_vertex r_skid;
    logic    in_fire;
    logic    can_load;

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    // Stage register takes a new item when empty or when it moves on
    assign can_load = !r_valid || i_advance;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (can_load) begin
            r_valid      <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_item <= r_skid_valid ? r_skid : i_item;
        end else if (in_fire) begin
            r_skid <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/tpa_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_core
// Corner slots, primitive phase and triangle counter. Decodes one vertex per
// step and reports whether it completes a triangle.
// ----------------------------------------------------------------------------
module tpa_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tpa_pkg::t_vertex   i_item,
    output logic               o_emit,
    output tpa_pkg::t_triangle o_tri
);
    import tpa_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ZERO  = '0;
    localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_TWO   = POSITION_BITS'(2);
    localparam logic [POSITION_BITS-1:0] POS_FOUR  = POSITION_BITS'(4);
    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;

    logic [VERTEX_ID_BITS-1:0] r_slot_a, r_slot_b, r_slot_c;
    logic [VERTEX_ID_BITS-1:0] n_slot_a, n_slot_b, n_slot_c;
    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    logic [TRI_NUM_BITS-1:0]   r_count, n_count;

    logic [VERTEX_ID_BITS-1:0] vid;
    logic [POSITION_BITS-1:0]  pos;
    logic [POSITION_BITS-1:0]  pos_q;
    logic [TRI_NUM_BITS-1:0]   count;
    logic                      emit;
    logic                      is_strip;

    assign vid      = i_item.vertex_id[VERTEX_ID_BITS-1:0];
    assign pos      = i_item.first_vertex ? POS_ZERO : r_pos;
    assign count    = i_item.restart_count ? '0 : r_count;
    assign is_strip = (i_item.prim_type == PRIM_TRI_STRIP) ||
                      (i_item.prim_type == PRIM_QUAD_STRIP);
    // Quads wrap after four vertices
    assign pos_q    = (pos >= POS_FOUR) ? POS_ZERO : pos;

    // Per-type decode of the vertex against the current phase
    always_comb begin
        n_slot_a = r_slot_a;
        n_slot_b = r_slot_b;
        n_slot_c = r_slot_c;
        n_pos    = pos;
        emit     = 1'b0;
        unique case (i_item.prim_type)
            PRIM_TRIANGLES: begin
                if (pos == POS_ONE) begin
                    n_slot_b = vid;
                    n_pos    = POS_TWO;
                end else if (pos == POS_TWO) begin
                    n_slot_c = vid;
                    n_pos    = POS_ZERO;
                    emit     = 1'b1;
                end else begin
                    // phase zero, or three and above taken as zero
                    n_slot_a = vid;
                    n_pos    = POS_ONE;
                end
            end
            PRIM_QUADS: begin
                n_pos = pos_q + POS_ONE;
                if (pos_q == POS_ZERO) begin
                    n_slot_a = vid;
                end else if (pos_q == POS_ONE) begin
                    n_slot_b = vid;
                end else if (pos_q == POS_TWO) begin
                    n_slot_c = vid;
                    emit     = 1'b1;
                end else begin
                    // second half: (v0, v2, v3)
                    n_slot_b = r_slot_c;
                    n_slot_c = vid;
                    n_pos    = POS_ZERO;
                    emit     = 1'b1;
                end
            end
            PRIM_TRI_STRIP, PRIM_QUAD_STRIP, PRIM_TRI_FAN, PRIM_POLYGON: begin
                n_pos = (pos == POS_MAX) ? POS_FOUR : pos + POS_ONE;
                if (pos == POS_ZERO) begin
                    n_slot_a = vid;
                end else if (pos == POS_ONE) begin
                    n_slot_b = vid;
                end else if (pos == POS_TWO) begin
                    n_slot_c = vid;
                    emit     = 1'b1;
                end else begin
                    // strips on odd phase replace corner a to keep winding
                    if (is_strip && pos[0]) begin
                        n_slot_a = r_slot_c;
                    end else begin
                        n_slot_b = r_slot_c;
                    end
                    n_slot_c = vid;
                    emit     = 1'b1;
                end
            end
            default: begin
                // points, lines and unknown types: phase held, nothing out
                n_pos = pos;
            end
        endcase
    end

    assign n_count = emit ? count + TRI_NUM_BITS'(1) : count;

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_a <= '0;
            r_slot_b <= '0;
            r_slot_c <= '0;
            r_pos    <= '0;
            r_count  <= '0;
        end else if (i_step) begin
            r_slot_a <= n_slot_a;
            r_slot_b <= n_slot_b;
            r_slot_c <= n_slot_c;
            r_pos    <= n_pos;
            r_count  <= n_count;
        end
    end

    assign o_emit                = emit;
    assign o_tri.corner_a        = PORT_ID_BITS'(n_slot_a);
    assign o_tri.corner_b        = PORT_ID_BITS'(n_slot_b);
    assign o_tri.corner_c        = PORT_ID_BITS'(n_slot_c);
    assign o_tri.triangle_number = count;

endmodule

@@ src/triangle_primitive_assembly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_primitive_assembly
// Splits a stream of GL primitive vertices into triangles.
//
// Channel   Direction  Handshake            Payload
// vertex    in         i_valid / o_stall    prim_type, first_vertex,
//                                           restart_count, vertex_id
// triangle  out        o_valid / i_stall    corner_a/b/c, triangle_number
//
// One vertex per cycle sustained while the output is not stalled; a vertex is
// taken into the input register, then decoded into the result register.
// The upstream stall is registered: a one-entry skid buffer absorbs the
// item in flight when the output is stalled.
// Synchronous active-low reset clears slots, phase and triangle number.
// ----------------------------------------------------------------------------
module triangle_primitive_assembly (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // vertex input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_prim_type,
    input  logic        i_first_vertex,
    input  logic        i_restart_count,
    input  logic [31:0] i_vertex_id,
    // triangle output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_corner_a,
    output logic [31:0] o_corner_b,
    output logic [31:0] o_corner_c,
    output logic [31:0] o_triangle_number
);
    import tpa_pkg::*;

    t_vertex   in_item;
    t_vertex   stage_item;
    logic      stage_valid;
    logic      advance;
    logic      core_emit;
    t_triangle core_tri;

    logic      r_out_valid;
    t_triangle r_out;

    assign in_item.prim_type     = t_prim_type'(i_prim_type);
    assign in_item.first_vertex  = i_first_vertex;
    assign in_item.restart_count = i_restart_count;
    assign in_item.vertex_id     = i_vertex_id;

    // Result register frees up when empty or when taken downstream
    assign advance = !r_out_valid || !i_stall;

    tpa_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    tpa_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (stage_valid && advance),
        .i_item  (stage_item),
        .o_emit  (core_emit),
        .o_tri   (core_tri)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_valid && core_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stage_valid && core_emit) begin
            r_out <= core_tri;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_corner_a        = r_out.corner_a;
    assign o_corner_b        = r_out.corner_b;
    assign o_corner_c        = r_out.corner_c;
    assign o_triangle_number = r_out.triangle_number;

endmodule

@@ verif/triangle_primitive_assembly_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_primitive_assembly_tb
// Self-checking bench for the GL primitive to triangle splitter.
//
// Vertex items are pushed through the valid/stall input while a checker
// compares every triangle that leaves the block with a queue of triangles
// predicted in the bench. Directed primitives of every type come first, then
// a long output hold, a full drain pause, random well-formed primitives mixed
// with noise and broken groups, a long strip that changes chain type over its
// last 39 vertices, and a final random stretch with no idling on either side.
// ----------------------------------------------------------------------------
module triangle_primitive_assembly_tb;
    import tpa_pkg::*;

    localparam int         CYCLE_LIMIT      = 1_500_000;
    localparam int         TAIL_CYCLES      = 16;
    localparam int         LONG_HOLD_CYCLES = 60;
    localparam int         LONG_STRIP_LEN   = 60;
    localparam int         MAX_PRINTED      = 50;
    localparam logic [3:0] TYPE_CODE_MAX    = 4'd15;
    localparam logic [PORT_ID_BITS-1:0] ID_MASK =
        PORT_ID_BITS'((64'd1 << VERTEX_ID_BITS) - 64'd1);

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_valid         = 1'b0;
    logic [3:0]              i_prim_type     = '0;
    logic                    i_first_vertex  = 1'b0;
    logic                    i_restart_count = 1'b0;
    logic [PORT_ID_BITS-1:0] i_vertex_id     = '0;
    logic                    i_stall         = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [PORT_ID_BITS-1:0] o_corner_a;
    logic [PORT_ID_BITS-1:0] o_corner_b;
    logic [PORT_ID_BITS-1:0] o_corner_c;
    logic [TRI_NUM_BITS-1:0] o_triangle_number;

    triangle_primitive_assembly DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_prim_type       (i_prim_type),
        .i_first_vertex    (i_first_vertex),
        .i_restart_count   (i_restart_count),
        .i_vertex_id       (i_vertex_id),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_corner_a        (o_corner_a),
        .o_corner_b        (o_corner_b),
        .o_corner_c        (o_corner_c),
        .o_triangle_number (o_triangle_number)
    );

    // Bench copy of the assembly state
    logic [PORT_ID_BITS-1:0]  corner_a_q   = '0;
    logic [PORT_ID_BITS-1:0]  corner_b_q   = '0;
    logic [PORT_ID_BITS-1:0]  corner_c_q   = '0;
    logic [POSITION_BITS-1:0] phase_q      = '0;
    logic [TRI_NUM_BITS-1:0]  next_tri_num = '0;
    t_triangle                expected_triangles[$];

    int errors         = 0;
    int vertices_sent  = 0;
    int triangles_seen = 0;
    int cycles         = 0;
    bit sender_idling  = 1'b0;
    bit stall_idling   = 1'b0;
    bit hold_request   = 1'b0;
    int sender_calm    = 0;

    // Clock
    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    // Place a vertex in the corner for phase 0, 1 or 2; phase 2 closes a triangle
    function automatic logic fill_corner(logic [POSITION_BITS-1:0] ph,
                                         logic [PORT_ID_BITS-1:0] vid);
        if (ph == 0) begin
            corner_a_q = vid;
            return 1'b0;
        end
        if (ph == 1) begin
            corner_b_q = vid;
            return 1'b0;
        end
        corner_c_q = vid;
        return 1'b1;
    endfunction

    // Advance the bench state by one accepted vertex; queue the triangle it closes
    function automatic void assemble_vertex(logic [3:0] pt, logic fv, logic rc,
                                            logic [PORT_ID_BITS-1:0] raw_id);
        logic [PORT_ID_BITS-1:0]  vid;
        logic [POSITION_BITS-1:0] ph;
        logic [POSITION_BITS-1:0] nxt;
        logic                     emit;
        t_triangle                shape;
        vid  = raw_id & ID_MASK;
        emit = 1'b0;
        if (rc) next_tri_num = '0;
        ph  = fv ? '0 : phase_q;
        nxt = ph;
        case (pt)
            PRIM_TRIANGLES: begin
                if (ph >= 3) ph = '0;
                emit = fill_corner(ph, vid);
                nxt  = (ph == 2) ? '0 : ph + 1'b1;
            end
            PRIM_QUADS: begin
                // fourth vertex reuses a and the previous c
                if (ph >= 4) ph = '0;
                if (ph == 3) begin
                    corner_b_q = corner_c_q;
                    corner_c_q = vid;
                    emit       = 1'b1;
                end else begin
                    emit = fill_corner(ph, vid);
                end
                nxt = (ph == 3) ? '0 : ph + 1'b1;
            end
            PRIM_TRI_STRIP, PRIM_QUAD_STRIP, PRIM_TRI_FAN, PRIM_POLYGON: begin
                if (ph < 3) begin
                    emit = fill_corner(ph, vid);
                end else begin
                    // strips replace a on odd phases to keep winding
                    if ((pt == PRIM_TRI_STRIP || pt == PRIM_QUAD_STRIP) && ph[0])
                        corner_a_q = corner_c_q;
                    else
                        corner_b_q = corner_c_q;
                    corner_c_q = vid;
                    emit       = 1'b1;
                end
                // saturated phase folds back to 4, keeping parity
                nxt = (ph == '1) ? POSITION_BITS'(4) : ph + 1'b1;
            end
            default: ;
        endcase
        phase_q = nxt;
        if (emit) begin
            shape.corner_a        = corner_a_q;
            shape.corner_b        = corner_b_q;
            shape.corner_c        = corner_c_q;
            shape.triangle_number = next_tri_num;
            expected_triangles.push_back(shape);
            next_tri_num = next_tri_num + 1'b1;
        end
    endfunction

    function automatic logic [PORT_ID_BITS-1:0] pick_vertex_id();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_any_type();
        return 4'($urandom_range(0, TYPE_CODE_MAX));
    endfunction

    function automatic logic [3:0] pick_chain_type();
        case ($urandom_range(0, 3))
            0:       return PRIM_TRI_STRIP;
            1:       return PRIM_QUAD_STRIP;
            2:       return PRIM_TRI_FAN;
            default: return PRIM_POLYGON;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Drop valid and hold off; the random gaps in the sender start here
    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Valid drops only while something is still outstanding
    task automatic drain_expected();
        while (expected_triangles.size() != 0) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Offer one vertex item and wait until the block takes it
    task automatic send_vertex(logic [3:0] pt, logic fv, logic rc,
                               logic [PORT_ID_BITS-1:0] vid);
        if (sender_idling) begin
            if (sender_calm > 0)
                sender_calm--;
            else if ($urandom_range(0, 31) == 0)
                sender_calm = $urandom_range(10, 60);
            else if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
        end
        i_valid         <= 1'b1;
        i_prim_type     <= pt;
        i_first_vertex  <= fv;
        i_restart_count <= rc;
        i_vertex_id     <= vid;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        assemble_vertex(pt, fv, rc, vid);
        vertices_sent++;
    endtask

    task automatic send_primitive(logic [3:0] pt, int len, logic rc);
        for (int k = 0; k < len; k++)
            send_vertex(pt, k == 0, rc && k == 0, pick_vertex_id());
    endtask

    // Every type at least once, extreme ids, flags, short and partial primitives
    task automatic test_directed_cases();
        // restart and first together, extreme ids
        send_vertex(PRIM_TRIANGLES, 1'b1, 1'b1, '0);
        send_vertex(PRIM_TRIANGLES, 1'b0, 1'b0, '1);
        send_vertex(PRIM_TRIANGLES, 1'b0, 1'b0, 32'h8000_0001);
        // leftover vertex of an unfinished triple
        send_vertex(PRIM_TRIANGLES, 1'b0, 1'b0, 32'h7FFF_FFFE);
        send_primitive(PRIM_QUADS, 4, 1'b0);
        send_primitive(PRIM_TRI_STRIP, 4, 1'b1);
        send_primitive(PRIM_QUAD_STRIP, 4, 1'b0);
        send_primitive(PRIM_TRI_FAN, 4, 1'b0);
        // restart in the middle of a fan
        send_vertex(PRIM_TRI_FAN, 1'b0, 1'b1, pick_vertex_id());
        // type change mid-primitive: triangles at a high phase start over
        send_vertex(PRIM_TRIANGLES, 1'b0, 1'b0, pick_vertex_id());
        send_vertex(PRIM_QUADS, 1'b0, 1'b0, pick_vertex_id());
        send_primitive(PRIM_POLYGON, 3, 1'b0);
        // too short to give a triangle
        send_primitive(PRIM_POLYGON, 2, 1'b0);
        // types that give nothing; a first vertex still clears the phase
        send_vertex(PRIM_POINTS, 1'b1, 1'b0, pick_vertex_id());
        send_vertex(PRIM_LINES, 1'b0, 1'b0, pick_vertex_id());
        send_vertex(PRIM_LINE_LOOP, 1'b1, 1'b1, pick_vertex_id());
        send_vertex(PRIM_LINE_STRIP, 1'b0, 1'b0, pick_vertex_id());
        send_vertex(TYPE_CODE_MAX, 1'b1, 1'b0, pick_vertex_id());
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_output_hold();
        bit saved;
        saved         = sender_idling;
        sender_idling = 1'b0;
        hold_request  = 1'b1;
        send_primitive(PRIM_TRI_STRIP, 40, 1'b0);
        sender_idling = saved;
    endtask

    // Sender stops until every pending triangle is out, then resumes
    task automatic test_drain_pause();
        send_primitive(PRIM_TRI_FAN, 6, 1'b0);
        drain_expected();
        send_primitive(PRIM_QUADS, 8, 1'b1);
    endtask

    // Mostly well-formed primitives with random content, some noise
    task automatic test_random_primitives(int target);
        int         done;
        int         len;
        int         pick;
        logic [3:0] pt;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pt  = 4'($urandom_range(PRIM_TRIANGLES, PRIM_POLYGON));
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 13);
                for (int k = 0; k < len; k++)
                    send_vertex(($urandom_range(0, 49) == 0) ? pick_any_type() : pt,
                                k == 0, $urandom_range(0, 39) == 0, pick_vertex_id());
                done += len;
            end else if (pick < 8) begin
                // noise: any code, any flags
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_vertex(pick_any_type(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), pick_vertex_id());
            end else begin
                // broken group of triangles or quads
                pt  = $urandom_range(0, 1) ? PRIM_TRIANGLES : PRIM_QUADS;
                len = $urandom_range(1, 3);
                send_primitive(pt, len, 1'($urandom_range(0, 1)));
                done += len;
            end
            if ($urandom_range(0, 59) == 0) drain_expected();
        end
    endtask

    // Long strip at full rate, mixed chain types over its last 39 vertices
    task automatic test_long_strip();
        logic [3:0] pt;
        sender_idling = 1'b0;
        stall_idling  = 1'b0;
        for (int k = 0; k < LONG_STRIP_LEN; k++) begin
            pt = (k > LONG_STRIP_LEN - 40) ? pick_chain_type() : PRIM_TRI_STRIP;
            send_vertex(pt, k == 0, 1'b0, $urandom);
        end
    endtask

    // Receiver stall: random bursts, calm stretches, one long hold on request
    initial begin : output_stall
        int calm;
        calm = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_idling) begin
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 31) == 0) begin
                    calm = $urandom_range(10, 60);
                end else if ($urandom_range(0, 5) == 0) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 9)) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each accepted triangle with the oldest prediction
    initial begin : triangle_check
        t_triangle want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                triangles_seen++;
                if (expected_triangles.size() == 0) begin
                    report_mismatch($sformatf("unexpected triangle %h %h %h number %h",
                                              o_corner_a, o_corner_b, o_corner_c,
                                              o_triangle_number));
                end else begin
                    want = expected_triangles.pop_front();
                    check_field("corner_a", o_corner_a, want.corner_a);
                    check_field("corner_b", o_corner_b, want.corner_b);
                    check_field("corner_c", o_corner_c, want.corner_c);
                    check_field("triangle_number", o_triangle_number,
                                want.triangle_number);
                end
            end
        end
    end

    // Cycle limit
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d triangles outstanding",
                 cycles, expected_triangles.size());
        $display("** triangle_primitive_assembly: FAILED **");
        $finish;
    end

    // Test sequence
    initial begin : run_tests
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        sender_idling = 1'b1;
        stall_idling  = 1'b1;
        test_output_hold();
        test_drain_pause();
        test_random_primitives(1350);
        test_long_strip();
        // closing stretch runs with both sides always ready
        test_random_primitives(100);
        drain_expected();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d vertices in, %0d triangles checked, all 16 type codes,",
                 vertices_sent, triangles_seen);
        $display("     a %0d-vertex mixed strip, long output hold, %0d mismatches",
                 LONG_STRIP_LEN, errors);
        if (errors == 0)
            $display("** triangle_primitive_assembly: PASSED **");
        else
            $display("** triangle_primitive_assembly: FAILED **");
        $finish;
    end

endmodule
